/* design/tipc_pkg.sv */
// shared constants, status codes and word widths for the impact parameter chi2 pipeline
`default_nettype none

package tipc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NONPOS = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  // slope fixed point: a slope of one is 2^SLOPE_FRAC
  localparam int SLOPE_FRAC = 20;

  // quotient lengths of the two dividers
  localparam int IP_QBITS  = 64;
  localparam int CHI_QBITS = 32;

  // operand widths of the dividers
  localparam int C2_W = 114;
  localparam int S2_W = 48;
  localparam int C4_W = 228;
  localparam int QM_W = 194;
  localparam int Q_W  = 196;

  // stages ahead of the dividers
  localparam int FRONT_STAGES = 15;

endpackage

`default_nettype wire

/* design/track_impact_parameter_chi2.sv */
// impact parameter squared and chi2 of a straight track to a vertex, fully pipelined
// 15 arithmetic stages, 64 one-bit divider stages and one output register
// throughput: one word per cycle; the whole pipeline halts while a result waits on out_ready
// reset: synchronous active-low rst_n clears all stage valid bits and the output valid
`default_nettype none

module track_impact_parameter_chi2 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_track_x,
  input  logic signed [31:0] in_track_y,
  input  logic signed [31:0] in_track_z,
  input  logic signed [23:0] in_slope_x,
  input  logic signed [23:0] in_slope_y,
  input  logic        [31:0] in_cov_xx,
  input  logic signed [31:0] in_cov_xy,
  input  logic        [31:0] in_cov_yy,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic signed [31:0] in_vertex_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [63:0] out_ip_squared,
  output logic        [31:0] out_chi2_value,
  output logic        [1:0]  out_status
);

  // side-band carried along the front stages
  typedef struct packed {
    logic                               vld;
    logic                               zero;
    logic [31:0]                        kxx;
    logic [31:0]                        kyy;
    logic [31:0]                        kxym;
    logic                               kxyn;
    logic [tipc_pkg::S2_W-1:0]          s2;
    logic [tipc_pkg::C2_W-1:0]          c2;
    logic [tipc_pkg::C4_W-1:0]          c4;
    logic                               sxy;
    logic signed [tipc_pkg::Q_W-1:0]    q;
    logic [tipc_pkg::QM_W-1:0]          qm;
    logic                               qbad;
    logic                               ipsat;
    logic                               chisat;
  } meta_t;

  // one divider stage
  typedef struct packed {
    logic                               vld;
    logic                               zero;
    logic                               qbad;
    logic                               ipsat;
    logic                               chisat;
    logic [tipc_pkg::C2_W-1:0]          iprem;
    logic [tipc_pkg::S2_W-1:0]          ipd;
    logic [tipc_pkg::IP_QBITS-1:0]      ipq;
    logic [tipc_pkg::C4_W-1:0]          crem;
    logic [tipc_pkg::QM_W-1:0]          cd;
    logic [tipc_pkg::CHI_QBITS-1:0]     cq;
  } div_t;

  logic adv;

  meta_t meta_r   [1:tipc_pkg::FRONT_STAGES];
  meta_t meta_nxt [1:tipc_pkg::FRONT_STAGES];

  // stage 1: differences
  logic signed [32:0] p1_dx_r, p1_dy_r, p1_dz_r;
  logic signed [23:0] p1_tx_r, p1_ty_r;
  // stage 2: cross product terms
  logic signed [56:0] p2_pzy_r, p2_pzx_r, p2_pxy_r, p2_pyx_r;
  logic signed [32:0] p2_dx_r, p2_dy_r;
  logic signed [23:0] p2_tx_r, p2_ty_r;
  logic        [47:0] p2_txx_r, p2_tyy_r;
  // stage 3: cross product
  logic signed [57:0] p3_cx_r, p3_cy_r, p3_cz_r;
  logic signed [23:0] p3_tx_r, p3_ty_r;
  // stage 4: magnitudes
  logic        [55:0] p4_mc_r [3];
  logic               p4_scz_r;
  logic signed [57:0] p4_cx_r, p4_cy_r;
  logic        [23:0] p4_mtx_r, p4_mty_r;
  logic               p4_stx_r, p4_sty_r;
  // stage 5: partial products
  logic        [55:0] p5_sq_r [3][3];
  logic        [51:0] p5_tyz_lo_r, p5_tyz_hi_r, p5_txz_lo_r, p5_txz_hi_r;
  logic               p5_syz_r, p5_sxz_r;
  logic signed [57:0] p5_cx_r, p5_cy_r;
  // stage 6: squares and slope products
  logic        [111:0] p6_sq_r [3];
  logic        [79:0]  p6_tyz_r, p6_txz_r;
  logic                p6_syz_r, p6_sxz_r;
  logic signed [57:0]  p6_cx_r, p6_cy_r;
  // stage 7: projected vector
  logic signed [81:0] p7_px_r, p7_py_r;
  // stage 8: magnitudes and c2 squared partial products
  logic [79:0] p8_mp_r [2];
  logic [57:0] p8_c4pp_r [4][4];
  // stage 9 to 13: quadratic form
  logic [53:0]  p9_qpp_r [3][3][3];
  logic [143:0] p9_c4row_r [4];
  logic [107:0] p10_qrow_r [3][3];
  logic [159:0] p11_qsq_r [3];
  logic [63:0]  p12_kpp_r [3][5];
  logic [191:0] p13_term_r [3];

  div_t dv_r   [tipc_pkg::IP_QBITS];
  div_t dv_nxt [tipc_pkg::IP_QBITS];

  logic                  out_vld_r;
  logic [63:0]           out_ip_r;
  logic [31:0]           out_chi_r;
  tipc_pkg::status_t     out_st_r;

  // combinational helpers
  logic [26:0]  p8_limb [2][3];
  logic [143:0] c4row_sum [4];
  logic [107:0] qrow_sum [3][3];
  logic [159:0] qsq_sum [3];
  logic [191:0] term_sum [3];
  logic [tipc_pkg::C4_W-1:0] c4_sum;
  logic         term_neg;

  // global advance: the pipeline moves while the output register is free or drained
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // side-band next values
  always_comb begin
    meta_nxt[1]       = '0;
    meta_nxt[1].vld   = in_valid;
    meta_nxt[1].kxx   = in_cov_xx;
    meta_nxt[1].kyy   = in_cov_yy;
    meta_nxt[1].kxym  = in_cov_xy[31] ? 32'(-in_cov_xy) : in_cov_xy;
    meta_nxt[1].kxyn  = in_cov_xy[31];
    for (int k = 2; k <= tipc_pkg::FRONT_STAGES; k++) begin
      meta_nxt[k] = meta_r[k-1];
    end
    meta_nxt[3].s2    = p2_txx_r + p2_tyy_r + (48'd1 << (2 * tipc_pkg::SLOPE_FRAC));
    meta_nxt[4].zero  = (p3_cx_r == '0) && (p3_cy_r == '0) && (p3_cz_r == '0);
    meta_nxt[7].c2    = 114'(p6_sq_r[0]) + 114'(p6_sq_r[1]) + 114'(p6_sq_r[2]);
    meta_nxt[8].sxy   = p7_px_r[81] ^ p7_py_r[81];
    meta_nxt[10].c4   = c4_sum;
    meta_nxt[14].q    = $signed({4'b0, p13_term_r[0]}) + $signed({4'b0, p13_term_r[1]})
                        + (term_neg ? -$signed({3'b0, p13_term_r[2], 1'b0})
                                    :  $signed({3'b0, p13_term_r[2], 1'b0}));
    meta_nxt[15].qm     = meta_r[14].q[tipc_pkg::QM_W-1:0];
    meta_nxt[15].qbad   = meta_r[14].q[tipc_pkg::Q_W-1] || (meta_r[14].q == '0);
    meta_nxt[15].ipsat  = meta_r[14].c2 >= {meta_r[14].s2, 64'b0};
    meta_nxt[15].chisat = meta_r[14].c4 >= {meta_r[14].q[tipc_pkg::QM_W-1:0], 32'b0};
  end

  assign term_neg = meta_r[13].sxy ^ meta_r[13].kxyn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= tipc_pkg::FRONT_STAGES; k++) begin
        meta_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      meta_r <= meta_nxt;
    end
  end

  // limb split of the projected vector magnitudes
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      for (int i = 0; i < 3; i++) begin
        p8_limb[t][i] = 27'(p8_mp_r[t] >> (27 * i));
      end
    end
  end

  // shifted partial product sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      c4row_sum[i] = '0;
      for (int j = 0; j < 4; j++) begin
        c4row_sum[i] = c4row_sum[i] + (144'(p8_c4pp_r[i][j]) << (29 * j));
      end
    end
    c4_sum = '0;
    for (int i = 0; i < 4; i++) begin
      c4_sum = c4_sum + (228'(p9_c4row_r[i]) << (29 * i));
    end
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < 3; i++) begin
        qrow_sum[t][i] = '0;
        for (int j = 0; j < 3; j++) begin
          qrow_sum[t][i] = qrow_sum[t][i] + (108'(p9_qpp_r[t][i][j]) << (27 * j));
        end
      end
      qsq_sum[t] = '0;
      for (int i = 0; i < 3; i++) begin
        qsq_sum[t] = qsq_sum[t] + (160'(p10_qrow_r[t][i]) << (27 * i));
      end
      term_sum[t] = '0;
      for (int i = 0; i < 5; i++) begin
        term_sum[t] = term_sum[t] + (192'(p12_kpp_r[t][i]) << (32 * i));
      end
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: track minus vertex
      p1_dx_r <= $signed({in_track_x[31], in_track_x}) - $signed({in_vertex_x[31], in_vertex_x});
      p1_dy_r <= $signed({in_track_y[31], in_track_y}) - $signed({in_vertex_y[31], in_vertex_y});
      p1_dz_r <= $signed({in_track_z[31], in_track_z}) - $signed({in_vertex_z[31], in_vertex_z});
      p1_tx_r <= in_slope_x;
      p1_ty_r <= in_slope_y;

      // stage 2: products of differences and slopes
      p2_pzy_r <= p1_dz_r * p1_ty_r;
      p2_pzx_r <= p1_dz_r * p1_tx_r;
      p2_pxy_r <= p1_dx_r * p1_ty_r;
      p2_pyx_r <= p1_dy_r * p1_tx_r;
      p2_txx_r <= p1_tx_r * p1_tx_r;
      p2_tyy_r <= p1_ty_r * p1_ty_r;
      p2_dx_r  <= p1_dx_r;
      p2_dy_r  <= p1_dy_r;
      p2_tx_r  <= p1_tx_r;
      p2_ty_r  <= p1_ty_r;

      // stage 3: cross product of difference and direction
      p3_cx_r <= $signed({p2_dy_r, 20'b0}) - p2_pzy_r;
      p3_cy_r <= p2_pzx_r - $signed({p2_dx_r, 20'b0});
      p3_cz_r <= p2_pxy_r - p2_pyx_r;
      p3_tx_r <= p2_tx_r;
      p3_ty_r <= p2_ty_r;

      // stage 4: magnitudes and signs
      p4_mc_r[0] <= 56'(p3_cx_r[57] ? -p3_cx_r : p3_cx_r);
      p4_mc_r[1] <= 56'(p3_cy_r[57] ? -p3_cy_r : p3_cy_r);
      p4_mc_r[2] <= 56'(p3_cz_r[57] ? -p3_cz_r : p3_cz_r);
      p4_scz_r   <= p3_cz_r[57];
      p4_cx_r    <= p3_cx_r;
      p4_cy_r    <= p3_cy_r;
      p4_mtx_r   <= p3_tx_r[23] ? 24'(-p3_tx_r) : p3_tx_r;
      p4_mty_r   <= p3_ty_r[23] ? 24'(-p3_ty_r) : p3_ty_r;
      p4_stx_r   <= p3_tx_r[23];
      p4_sty_r   <= p3_ty_r[23];

      // stage 5: half-word partial products
      for (int c = 0; c < 3; c++) begin
        p5_sq_r[c][0] <= p4_mc_r[c][27:0] * p4_mc_r[c][27:0];
        p5_sq_r[c][1] <= p4_mc_r[c][27:0] * p4_mc_r[c][55:28];
        p5_sq_r[c][2] <= p4_mc_r[c][55:28] * p4_mc_r[c][55:28];
      end
      p5_tyz_lo_r <= p4_mty_r * p4_mc_r[2][27:0];
      p5_tyz_hi_r <= p4_mty_r * p4_mc_r[2][55:28];
      p5_txz_lo_r <= p4_mtx_r * p4_mc_r[2][27:0];
      p5_txz_hi_r <= p4_mtx_r * p4_mc_r[2][55:28];
      p5_syz_r    <= p4_sty_r ^ p4_scz_r;
      p5_sxz_r    <= p4_stx_r ^ p4_scz_r;
      p5_cx_r     <= p4_cx_r;
      p5_cy_r     <= p4_cy_r;

      // stage 6: assemble squares and slope products
      for (int c = 0; c < 3; c++) begin
        p6_sq_r[c] <= (112'(p5_sq_r[c][2]) << 56) + (112'(p5_sq_r[c][1]) << 29)
                      + 112'(p5_sq_r[c][0]);
      end
      p6_tyz_r <= (80'(p5_tyz_hi_r) << 28) + 80'(p5_tyz_lo_r);
      p6_txz_r <= (80'(p5_txz_hi_r) << 28) + 80'(p5_txz_lo_r);
      p6_syz_r <= p5_syz_r;
      p6_sxz_r <= p5_sxz_r;
      p6_cx_r  <= p5_cx_r;
      p6_cy_r  <= p5_cy_r;

      // stage 7: direction cross impact vector, x and y
      p7_px_r <= (p6_syz_r ? -$signed({2'b0, p6_tyz_r}) : $signed({2'b0, p6_tyz_r}))
                 - $signed({p6_cy_r, 20'b0});
      p7_py_r <= $signed({p6_cx_r, 20'b0})
                 - (p6_sxz_r ? -$signed({2'b0, p6_txz_r}) : $signed({2'b0, p6_txz_r}));

      // stage 8: magnitudes, partial products of c2 squared
      p8_mp_r[0] <= 80'(p7_px_r[81] ? -p7_px_r : p7_px_r);
      p8_mp_r[1] <= 80'(p7_py_r[81] ? -p7_py_r : p7_py_r);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p8_c4pp_r[i][j] <= 29'(meta_r[7].c2 >> (29 * i)) * 29'(meta_r[7].c2 >> (29 * j));
        end
      end

      // stage 9: partial products of the quadratic terms, c2 squared rows
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p9_qpp_r[0][i][j] <= p8_limb[0][i] * p8_limb[0][j];
          p9_qpp_r[1][i][j] <= p8_limb[1][i] * p8_limb[1][j];
          p9_qpp_r[2][i][j] <= p8_limb[0][i] * p8_limb[1][j];
        end
      end
      p9_c4row_r <= c4row_sum;

      // stage 10 and 11: rows and full squares
      p10_qrow_r <= qrow_sum;
      p11_qsq_r  <= qsq_sum;

      // stage 12: covariance weights
      for (int i = 0; i < 5; i++) begin
        p12_kpp_r[0][i] <= p11_qsq_r[0][32*i +: 32] * meta_r[11].kxx;
        p12_kpp_r[1][i] <= p11_qsq_r[1][32*i +: 32] * meta_r[11].kyy;
        p12_kpp_r[2][i] <= p11_qsq_r[2][32*i +: 32] * meta_r[11].kxym;
      end

      // stage 13: weighted terms
      p13_term_r <= term_sum;
    end
  end

  // restoring dividers, one quotient bit per stage each
  always_comb begin
    div_t                      cur;
    logic [tipc_pkg::C2_W-1:0] ipt;
    logic [tipc_pkg::C4_W-1:0] ct;
    for (int k = 0; k < tipc_pkg::IP_QBITS; k++) begin
      ct = '0;
      if (k == 0) begin
        cur        = '0;
        cur.vld    = meta_r[tipc_pkg::FRONT_STAGES].vld;
        cur.zero   = meta_r[tipc_pkg::FRONT_STAGES].zero;
        cur.qbad   = meta_r[tipc_pkg::FRONT_STAGES].qbad;
        cur.ipsat  = meta_r[tipc_pkg::FRONT_STAGES].ipsat;
        cur.chisat = meta_r[tipc_pkg::FRONT_STAGES].chisat;
        cur.iprem  = meta_r[tipc_pkg::FRONT_STAGES].c2;
        cur.ipd    = meta_r[tipc_pkg::FRONT_STAGES].s2;
        cur.crem   = meta_r[tipc_pkg::FRONT_STAGES].c4;
        cur.cd     = meta_r[tipc_pkg::FRONT_STAGES].qm;
      end else begin
        cur = dv_r[k-1];
      end
      ipt = tipc_pkg::C2_W'(cur.ipd) << (tipc_pkg::IP_QBITS - 1 - k);
      if (cur.iprem >= ipt) begin
        cur.iprem = cur.iprem - ipt;
        cur.ipq[tipc_pkg::IP_QBITS-1-k] = 1'b1;
      end
      if (k < tipc_pkg::CHI_QBITS) begin
        ct = tipc_pkg::C4_W'(cur.cd) << (tipc_pkg::CHI_QBITS - 1 - k);
        if (cur.crem >= ct) begin
          cur.crem = cur.crem - ct;
          cur.cq[tipc_pkg::CHI_QBITS-1-k] = 1'b1;
        end
      end
      dv_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < tipc_pkg::IP_QBITS; k++) begin
        dv_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      dv_r <= dv_nxt;
    end
  end

  // output register: special cases and saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_r[tipc_pkg::IP_QBITS-1].vld;
      if (dv_r[tipc_pkg::IP_QBITS-1].zero) begin
        out_ip_r  <= '0;
        out_chi_r <= '0;
        out_st_r  <= tipc_pkg::ST_ZERO;
      end else begin
        out_ip_r <= dv_r[tipc_pkg::IP_QBITS-1].ipsat ? '1 : dv_r[tipc_pkg::IP_QBITS-1].ipq;
        if (dv_r[tipc_pkg::IP_QBITS-1].qbad) begin
          out_chi_r <= '0;
          out_st_r  <= tipc_pkg::ST_NONPOS;
        end else begin
          out_chi_r <= dv_r[tipc_pkg::IP_QBITS-1].chisat ? '1 : dv_r[tipc_pkg::IP_QBITS-1].cq;
          out_st_r  <= (dv_r[tipc_pkg::IP_QBITS-1].ipsat || dv_r[tipc_pkg::IP_QBITS-1].chisat)
                       ? tipc_pkg::ST_SAT : tipc_pkg::ST_OK;
        end
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_ip_squared = out_ip_r;
  assign out_chi2_value = out_chi_r;
  assign out_status     = out_st_r;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for the track impact parameter chi2 pipeline
`default_nettype none

module testbench;

  // one track-vertex word
  typedef struct {
    logic signed [31:0] track_x, track_y, track_z;
    logic signed [23:0] slope_x, slope_y;
    logic        [31:0] cov_xx;
    logic signed [31:0] cov_xy;
    logic        [31:0] cov_yy;
    logic signed [31:0] vertex_x, vertex_y, vertex_z;
  } track_word_t;

  // one result word
  typedef struct {
    logic [63:0]       ip_squared;
    logic [31:0]       chi2_value;
    tipc_pkg::status_t status;
  } ip_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_track_x, in_track_y, in_track_z;
  logic signed [23:0] in_slope_x, in_slope_y;
  logic        [31:0] in_cov_xx;
  logic signed [31:0] in_cov_xy;
  logic        [31:0] in_cov_yy;
  logic signed [31:0] in_vertex_x, in_vertex_y, in_vertex_z;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_ip_squared;
  logic [31:0] out_chi2_value;
  logic [1:0]  out_status;

  ip_result_t expected_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit sink_steady = 0;
  bit source_steady = 0;
  int sink_hold = 0;

  track_impact_parameter_chi2 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_track_x(in_track_x), .in_track_y(in_track_y), .in_track_z(in_track_z),
    .in_slope_x(in_slope_x), .in_slope_y(in_slope_y),
    .in_cov_xx(in_cov_xx), .in_cov_xy(in_cov_xy), .in_cov_yy(in_cov_yy),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ip_squared(out_ip_squared), .out_chi2_value(out_chi2_value),
    .out_status(out_status)
  );

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // random gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // exact integer impact parameter and chi2
  function automatic ip_result_t predict_ip_chi2(track_word_t w);
    logic signed [319:0] one, dx, dy, dz, tx, ty, kxx, kxy, kyy;
    logic signed [319:0] cx, cy, cz, c2, s2, px, py, q, c4, quot;
    ip_result_t r;
    one = 320'sd1 <<< tipc_pkg::SLOPE_FRAC;
    dx = w.track_x; dx = dx - w.vertex_x;
    dy = w.track_y; dy = dy - w.vertex_y;
    dz = w.track_z; dz = dz - w.vertex_z;
    tx = w.slope_x;
    ty = w.slope_y;
    kxx = $signed({288'd0, w.cov_xx});
    kyy = $signed({288'd0, w.cov_yy});
    kxy = w.cov_xy;
    cx = dy * one - dz * ty;
    cy = dz * tx - dx * one;
    cz = dx * ty - dy * tx;
    r.ip_squared = '0;
    r.chi2_value = '0;
    r.status = tipc_pkg::ST_OK;
    if (cx == 0 && cy == 0 && cz == 0) begin
      r.status = tipc_pkg::ST_ZERO;
      return r;
    end
    c2 = cx * cx + cy * cy + cz * cz;
    s2 = tx * tx + ty * ty + one * one;
    quot = c2 / s2;
    if (quot >= (320'sd1 <<< tipc_pkg::IP_QBITS)) begin
      r.ip_squared = '1;
      r.status = tipc_pkg::ST_SAT;
    end else begin
      r.ip_squared = quot[63:0];
    end
    px = ty * cz - one * cy;
    py = one * cx - tx * cz;
    q = px * px * kxx + py * py * kyy + 2 * px * py * kxy;
    if (q <= 0) begin
      r.status = tipc_pkg::ST_NONPOS;
    end else begin
      c4 = c2 * c2;
      quot = c4 / q;
      if (quot >= (320'sd1 <<< tipc_pkg::CHI_QBITS)) begin
        r.chi2_value = '1;
        r.status = tipc_pkg::ST_SAT;
      end else begin
        r.chi2_value = quot[31:0];
      end
    end
    return r;
  endfunction

  // drive one word, wait for it to be taken, then record its expectation
  task automatic send_track(track_word_t w);
    int gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_track_x <= w.track_x; in_track_y <= w.track_y; in_track_z <= w.track_z;
    in_slope_x <= w.slope_x; in_slope_y <= w.slope_y;
    in_cov_xx <= w.cov_xx; in_cov_xy <= w.cov_xy; in_cov_yy <= w.cov_yy;
    in_vertex_x <= w.vertex_x; in_vertex_y <= w.vertex_y; in_vertex_z <= w.vertex_z;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    expected_results.insert(expected_results.size(), predict_ip_chi2(w));
    words_sent++;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  // compare each taken result with the oldest expectation
  always @(negedge clk) begin
    ip_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        $display("result word with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_ip_squared !== want.ip_squared)
          report_mismatch("ip_squared", out_ip_squared, want.ip_squared);
        if (out_chi2_value !== want.chi2_value)
          report_mismatch("chi2_value", 64'(out_chi2_value), 64'(want.chi2_value));
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
      end
    end
  end

  // fully random word over every field range
  function automatic track_word_t wild_track();
    track_word_t w;
    w.track_x = $urandom; w.track_y = $urandom; w.track_z = $urandom;
    w.slope_x = 24'($urandom); w.slope_y = 24'($urandom);
    w.cov_xx = $urandom; w.cov_xy = $urandom; w.cov_yy = $urandom;
    w.vertex_x = $urandom; w.vertex_y = $urandom; w.vertex_z = $urandom;
    return w;
  endfunction

  // physically plausible word: vertex near the track, sensible errors
  function automatic track_word_t plausible_track();
    track_word_t w;
    int dz;
    w.vertex_x = $signed($urandom_range(400000)) - 200000;
    w.vertex_y = $signed($urandom_range(400000)) - 200000;
    w.vertex_z = $signed($urandom_range(20000000)) - 10000000;
    w.slope_x = 24'($signed($urandom_range(600000)) - 300000);
    w.slope_y = 24'($signed($urandom_range(600000)) - 300000);
    dz = $signed($urandom_range(4000000)) - 2000000;
    w.track_z = w.vertex_z + dz;
    w.track_x = 32'(w.vertex_x + ((longint'(dz) * w.slope_x) >>> 20)
                + $signed($urandom_range(2000)) - 1000);
    w.track_y = 32'(w.vertex_y + ((longint'(dz) * w.slope_y) >>> 20)
                + $signed($urandom_range(2000)) - 1000);
    w.cov_xx = $urandom_range(1 << 20, 1 << 8);
    w.cov_yy = $urandom_range(1 << 20, 1 << 8);
    w.cov_xy = $signed($urandom_range(512)) - 256;
    return w;
  endfunction

  // field extremes
  task automatic test_extremes();
    track_word_t w;
    w = wild_track();
    w.track_x = 32'h7fffffff; w.track_y = 32'h80000000; w.track_z = 32'h7fffffff;
    w.vertex_x = 32'h80000000; w.vertex_y = 32'h7fffffff; w.vertex_z = 32'h80000000;
    w.slope_x = 24'h7fffff; w.slope_y = 24'h800000;
    w.cov_xx = '1; w.cov_yy = '1; w.cov_xy = 32'h80000000;
    send_track(w);
    w.slope_x = 24'h800000; w.slope_y = 24'h7fffff; w.cov_xy = 32'h7fffffff;
    send_track(w);
    w.cov_xx = 1; w.cov_yy = 1; w.cov_xy = 0;
    send_track(w);
    w.slope_x = '0; w.slope_y = '0; w.track_x = 1; w.vertex_x = 0;
    w.track_y = 0; w.vertex_y = 0;
    send_track(w);
    w.cov_xx = '1; w.cov_yy = 0;
    send_track(w);
  endtask

  // track passing exactly through the vertex
  task automatic test_zero_ip();
    track_word_t w;
    w = plausible_track();
    w.track_x = w.vertex_x; w.track_y = w.vertex_y; w.track_z = w.vertex_z;
    send_track(w);
    w.track_z = w.vertex_z + (1 << 20);
    w.track_x = w.vertex_x + w.slope_x;
    w.track_y = w.vertex_y + w.slope_y;
    send_track(w);
    w = wild_track();
    w.vertex_x = w.track_x; w.vertex_y = w.track_y; w.vertex_z = w.track_z;
    send_track(w);
  endtask

  // covariance zero or not positive in the projected direction
  task automatic test_nonpositive_error();
    track_word_t w;
    w = plausible_track();
    w.cov_xx = 0; w.cov_yy = 0; w.cov_xy = 0;
    send_track(w);
    w.cov_xx = 1; w.cov_yy = 1; w.cov_xy = 32'h7fffffff;
    send_track(w);
    w.cov_xy = 32'h80000000;
    send_track(w);
    w.slope_x = '0; w.slope_y = '0; w.track_y = w.vertex_y; w.track_x = w.vertex_x + 5000;
    w.cov_xx = 0; w.cov_yy = 1000; w.cov_xy = 0;
    send_track(w);
  endtask

  // saturating chi2 and ip_squared
  task automatic test_saturation();
    track_word_t w;
    w = plausible_track();
    w.track_x = 32'h7fffffff; w.vertex_x = 32'h80000000;
    w.cov_xx = 1; w.cov_yy = 1; w.cov_xy = 0;
    send_track(w);
    w.track_y = 32'h80000000; w.vertex_y = 32'h7fffffff;
    w.track_z = 32'h80000000; w.vertex_z = 32'h7fffffff;
    w.slope_x = 24'h7fffff; w.slope_y = 24'h7fffff;
    send_track(w);
    w.cov_xx = '1; w.cov_yy = '1;
    send_track(w);
  endtask

  // random words, bursts with and without idling
  task automatic test_random(int count);
    track_word_t w;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        source_steady = ($urandom_range(3) == 0);
        sink_steady = ($urandom_range(3) == 0);
      end
      r = $urandom_range(99);
      if (r < 60) w = plausible_track();
      else w = wild_track();
      if (r < 5) begin
        w.track_x = w.vertex_x; w.track_y = w.vertex_y; w.track_z = w.vertex_z;
      end else if (r < 10) begin
        w.cov_xy = $urandom; w.cov_xx = $urandom_range(16); w.cov_yy = $urandom_range(16);
      end
      send_track(w);
    end
    source_steady = 0;
    sink_steady = 0;
  endtask

  // stimulus and final verdict
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_track_x, in_track_y, in_track_z, in_vertex_x, in_vertex_y, in_vertex_z} = '0;
    {in_slope_x, in_slope_y, in_cov_xx, in_cov_xy, in_cov_yy} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_ip();
    test_nonpositive_error();
    test_saturation();
    test_random(1235);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d words sent, %0d results checked", words_sent, results_seen);
    $display("status counts ok/zero/nonpositive/saturated: %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
